>>> rtl/core/bdp_pkg.sv
// ----------------------------------------------------------------------------
// bdp_pkg
// shared types and constants of the branch direction predictor bank
// ----------------------------------------------------------------------------
`default_nettype none

package bdp_pkg;

  // address width of the branch pc and target
  localparam int unsigned ADDR_W = 64;

  // stream payload widths, rounded up to whole bytes
  localparam int unsigned IN_FIELDS_W  = 2 * ADDR_W + 1;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = 9;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // input tdata field positions
  localparam int unsigned PC_LSB     = 0;
  localparam int unsigned TAKEN_BIT  = ADDR_W;
  localparam int unsigned TARGET_LSB = ADDR_W + 1;

  // one result item
  typedef struct packed {
    logic tournament_pred;
    logic vote_pred;
    logic pair_hybrid_pred;
    logic gshare_pred;
    logic global_pred;
    logic local_pred;
    logic bimodal_pred;
    logic static_pred;
    logic is_forward;
  } pred_t;

endpackage

`default_nettype wire

>>> rtl/core/bdp_ram.sv
// ----------------------------------------------------------------------------
// bdp_ram
// one write port, one registered read port, write-first on address match
// ----------------------------------------------------------------------------
`default_nettype none

module bdp_ram #(
  parameter int unsigned AW = 9,
  parameter int unsigned DW = 2
) (
  input  wire logic          clk_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // a write to the read address in the same cycle is passed straight to the reader
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/bdp_ctr.sv
// ----------------------------------------------------------------------------
// bdp_ctr
// saturating up/down counter step, taken when the top bit is set
// ----------------------------------------------------------------------------
`default_nettype none

module bdp_ctr #(
  parameter int unsigned W = 2
) (
  input  wire logic [W-1:0] cur_i,
  input  wire logic         train_i,
  input  wire logic         up_i,
  output logic      [W-1:0] next_o,
  output logic              taken_o
);

  always_comb begin
    next_o = cur_i;
    if (train_i) begin
      if (up_i) begin
        if (cur_i != {W{1'b1}}) begin
          next_o = cur_i + W'(1);
        end
      end else begin
        if (cur_i != '0) begin
          next_o = cur_i - W'(1);
        end
      end
    end
  end

  assign taken_o = cur_i[W-1];

endmodule

`default_nettype wire

>>> rtl/core/bdp_resolve.sv
// ----------------------------------------------------------------------------
// bdp_resolve
// predictions from the counters read for one branch, and their trained values
// ----------------------------------------------------------------------------
`default_nettype none

module bdp_resolve #(
  parameter int unsigned SMALL_CTR_BITS  = 2,
  parameter int unsigned GLOBAL_CTR_BITS = 3
) (
  input  wire logic                       taken_i,
  input  wire logic                       fwd_i,
  input  wire logic [SMALL_CTR_BITS-1:0]  bim_i,
  input  wire logic [SMALL_CTR_BITS-1:0]  lpc_i,
  input  wire logic [GLOBAL_CTR_BITS-1:0] gpc_i,
  input  wire logic [GLOBAL_CTR_BITS-1:0] gsc_i,
  input  wire logic [SMALL_CTR_BITS-1:0]  pair_i,
  input  wire logic [SMALL_CTR_BITS-1:0]  lg_i,
  input  wire logic [SMALL_CTR_BITS-1:0]  gg_i,
  input  wire logic [SMALL_CTR_BITS-1:0]  gl_i,
  output bdp_pkg::pred_t                  pred_o,
  output logic      [SMALL_CTR_BITS-1:0]  bim_o,
  output logic      [SMALL_CTR_BITS-1:0]  lpc_o,
  output logic      [GLOBAL_CTR_BITS-1:0] gpc_o,
  output logic      [GLOBAL_CTR_BITS-1:0] gsc_o,
  output logic      [SMALL_CTR_BITS-1:0]  pair_o,
  output logic      [SMALL_CTR_BITS-1:0]  lg_o,
  output logic      [SMALL_CTR_BITS-1:0]  gg_o,
  output logic      [SMALL_CTR_BITS-1:0]  gl_o
);

  logic p_bim, p_loc, p_glb, p_gsh;
  logic s_pair, s_lg, s_gg, s_gl;

  // direction tables always train toward the outcome
  bdp_ctr #(.W(SMALL_CTR_BITS)) u_bim (
    .cur_i(bim_i), .train_i(1'b1), .up_i(taken_i), .next_o(bim_o), .taken_o(p_bim)
  );
  bdp_ctr #(.W(SMALL_CTR_BITS)) u_lpc (
    .cur_i(lpc_i), .train_i(1'b1), .up_i(taken_i), .next_o(lpc_o), .taken_o(p_loc)
  );
  bdp_ctr #(.W(GLOBAL_CTR_BITS)) u_gpc (
    .cur_i(gpc_i), .train_i(1'b1), .up_i(taken_i), .next_o(gpc_o), .taken_o(p_glb)
  );
  bdp_ctr #(.W(GLOBAL_CTR_BITS)) u_gsc (
    .cur_i(gsc_i), .train_i(1'b1), .up_i(taken_i), .next_o(gsc_o), .taken_o(p_gsh)
  );

  // choosers move only on disagreement, toward 1 when the first one was wrong
  bdp_ctr #(.W(SMALL_CTR_BITS)) u_pair (
    .cur_i(pair_i), .train_i(p_loc != p_glb), .up_i(p_loc != taken_i),
    .next_o(pair_o), .taken_o(s_pair)
  );
  bdp_ctr #(.W(SMALL_CTR_BITS)) u_lg (
    .cur_i(lg_i), .train_i(p_loc != p_glb), .up_i(p_loc != taken_i),
    .next_o(lg_o), .taken_o(s_lg)
  );
  bdp_ctr #(.W(SMALL_CTR_BITS)) u_gg (
    .cur_i(gg_i), .train_i(p_glb != p_gsh), .up_i(p_glb != taken_i),
    .next_o(gg_o), .taken_o(s_gg)
  );
  bdp_ctr #(.W(SMALL_CTR_BITS)) u_gl (
    .cur_i(gl_i), .train_i(p_gsh != p_loc), .up_i(p_gsh != taken_i),
    .next_o(gl_o), .taken_o(s_gl)
  );

  always_comb begin
    pred_o.is_forward       = fwd_i;
    pred_o.static_pred      = ~fwd_i;
    pred_o.bimodal_pred     = p_bim;
    pred_o.local_pred       = p_loc;
    pred_o.global_pred      = p_glb;
    pred_o.gshare_pred      = p_gsh;
    pred_o.pair_hybrid_pred = s_pair ? p_glb : p_loc;
    pred_o.vote_pred        = (p_loc & p_glb) | (p_loc & p_gsh) | (p_glb & p_gsh);
    if (!s_lg) begin
      pred_o.tournament_pred = s_gl ? p_loc : p_gsh;
    end else begin
      pred_o.tournament_pred = s_gg ? p_gsh : p_glb;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/branch_direction_predictor_bank.sv
// ----------------------------------------------------------------------------
// branch_direction_predictor_bank
// eight direction predictions per resolved branch, then table training
// ----------------------------------------------------------------------------
// stages: stage 1, stage 2, output register; throughput: one branch per cycle
//   unless the output stalls; the tables sit in single-port-write rams with
//   write-first bypass, so back-to-back branches see each other's updates
// reset: history and pipeline clear at once, then a sweep writes zero to every
//   table entry, one per cycle, over max(table depths) entries (1024 by default);
//   s_axis_tready stays low during the sweep
// entry counts are powers of two
// ----------------------------------------------------------------------------
`default_nettype none

module branch_direction_predictor_bank #(
  parameter int unsigned GHIST_BITS      = 9,
  parameter int unsigned LOCAL_HIST_BITS = 9,
  parameter int unsigned LOCAL_ENTRIES   = 1024,
  parameter int unsigned BIMODAL_ENTRIES = 512,
  parameter int unsigned GLOBAL_CTR_BITS = 3,
  parameter int unsigned SMALL_CTR_BITS  = 2
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // branch_pc [63:0], branch_taken [64], branch_target [128:65], zero pad
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [bdp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // is_forward, static_pred, bimodal_pred, local_pred, global_pred,
  // gshare_pred, pair_hybrid_pred, vote_pred, tournament_pred, zero pad
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic      [bdp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  localparam int unsigned GHB = GHIST_BITS;
  localparam int unsigned LHB = LOCAL_HIST_BITS;
  localparam int unsigned SC  = SMALL_CTR_BITS;
  localparam int unsigned GC  = GLOBAL_CTR_BITS;
  localparam int unsigned LI_W = $clog2(LOCAL_ENTRIES);
  localparam int unsigned BI_W = $clog2(BIMODAL_ENTRIES);

  // the sweep covers the deepest table
  localparam int unsigned DEP_A = (LOCAL_ENTRIES > BIMODAL_ENTRIES) ?
                                  LOCAL_ENTRIES : BIMODAL_ENTRIES;
  localparam int unsigned DEP_B = (LHB > GHB) ? (2**LHB) : (2**GHB);
  localparam int unsigned CLR_DEPTH = (DEP_A > DEP_B) ? DEP_A : DEP_B;
  localparam int unsigned CLR_W = $clog2(CLR_DEPTH);
  localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_DEPTH - 1);

  // global-history-indexed word: pattern counter then the four choosers
  localparam int unsigned GW_DW    = GC + 4 * SC;
  localparam int unsigned PAIR_LSB = GC;
  localparam int unsigned LG_LSB   = GC + SC;
  localparam int unsigned GG_LSB   = GC + 2 * SC;
  localparam int unsigned GL_LSB   = GC + 3 * SC;

  localparam int unsigned PAD_W = bdp_pkg::OUT_TDATA_W - bdp_pkg::OUT_FIELDS_W;

  // input field views
  logic [bdp_pkg::ADDR_W-1:0] in_pc;
  logic [bdp_pkg::ADDR_W-1:0] in_target;
  logic                       in_taken;

  assign in_pc     = s_axis_tdata[bdp_pkg::PC_LSB +: bdp_pkg::ADDR_W];
  assign in_target = s_axis_tdata[bdp_pkg::TARGET_LSB +: bdp_pkg::ADDR_W];
  assign in_taken  = s_axis_tdata[bdp_pkg::TAKEN_BIT];

  // handshake and stage advance
  logic s_fire, s1_adv, s2_adv, m_fire;

  // control state
  logic             clr_q, clr_d;
  logic [CLR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [GHB-1:0]   gh_q, gh_d;
  logic             s1_valid_q, s1_valid_d;
  logic             s2_valid_q, s2_valid_d;
  logic             out_valid_q, out_valid_d;

  // stage 1 payload: local history is being read
  logic            s1_taken_q, s1_fwd_q;
  logic [BI_W-1:0] s1_bi_q;
  logic [LI_W-1:0] s1_li_q;
  logic [GHB-1:0]  s1_gh_q, s1_gsi_q;

  // stage 2 payload: counters are being read
  logic            s2_taken_q, s2_fwd_q;
  logic [BI_W-1:0] s2_bi_q;
  logic [LHB-1:0]  s2_lhist_q;
  logic [GHB-1:0]  s2_gh_q, s2_gsi_q;

  bdp_pkg::pred_t out_q;
  bdp_pkg::pred_t pred;

  // table ports
  logic [LHB-1:0]   lh_rdata, lh_wdata, lh_new;
  logic [LI_W-1:0]  lh_waddr;
  logic             lh_we;
  logic [SC-1:0]    bim_rdata, bim_new, bim_wdata;
  logic [BI_W-1:0]  bim_waddr;
  logic [SC-1:0]    lpc_rdata, lpc_new, lpc_wdata;
  logic [LHB-1:0]   lpc_waddr;
  logic [GW_DW-1:0] gw_rdata, gw_new, gw_wdata;
  logic [GHB-1:0]   gw_waddr;
  logic [GC-1:0]    gsc_rdata, gsc_new, gsc_wdata;
  logic [GHB-1:0]   gsc_waddr;
  logic             cnt_we;
  logic [GC-1:0]    gpc_new;
  logic [SC-1:0]    pair_new, lg_new, gg_new, gl_new;

  // a stage moves when the one after it is empty or moving too
  assign m_fire = m_axis_tvalid & m_axis_tready;
  assign s2_adv = s2_valid_q & (~out_valid_q | m_axis_tready);
  assign s1_adv = s1_valid_q & (~s2_valid_q | s2_adv);
  assign s_axis_tready = ~clr_q & (~s1_valid_q | s1_adv);
  assign s_fire = s_axis_tvalid & s_axis_tready;

  // control next state
  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + CLR_W'(1);
      if (clr_cnt_q == CLR_LAST) begin
        clr_d = 1'b0;
      end
    end

    // global history shifts as soon as a branch is taken in
    gh_d = s_fire ? {gh_q[GHB-2:0], in_taken} : gh_q;

    s1_valid_d  = s_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
    s2_valid_d  = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_q);
    out_valid_d = s2_adv ? 1'b1 : (m_fire ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
      gh_q        <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clr_q       <= clr_d;
      clr_cnt_q   <= clr_cnt_d;
      gh_q        <= gh_d;
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_taken_q <= in_taken;
      s1_fwd_q   <= (in_target >= in_pc);
      s1_bi_q    <= in_pc[BI_W-1:0];
      s1_li_q    <= in_pc[LI_W-1:0];
      s1_gh_q    <= gh_q;
      s1_gsi_q   <= in_pc[GHB-1:0] ^ gh_q;
    end
    if (s1_adv) begin
      s2_taken_q <= s1_taken_q;
      s2_fwd_q   <= s1_fwd_q;
      s2_bi_q    <= s1_bi_q;
      s2_lhist_q <= lh_rdata;
      s2_gh_q    <= s1_gh_q;
      s2_gsi_q   <= s1_gsi_q;
    end
    if (s2_adv) begin
      out_q <= pred;
    end
  end

  // local history: read on intake, rewritten when the branch leaves stage 1
  assign lh_new   = {lh_rdata[LHB-2:0], s1_taken_q};
  assign lh_we    = clr_q | s1_adv;
  assign lh_waddr = clr_q ? clr_cnt_q[LI_W-1:0] : s1_li_q;
  assign lh_wdata = clr_q ? '0 : lh_new;

  bdp_ram #(.AW(LI_W), .DW(LHB)) u_lh_ram (
    .clk_i   (clk_i),
    .re_i    (s_fire),
    .raddr_i (in_pc[LI_W-1:0]),
    .rdata_o (lh_rdata),
    .we_i    (lh_we),
    .waddr_i (lh_waddr),
    .wdata_i (lh_wdata)
  );

  // counter tables: read leaving stage 1, written leaving stage 2
  assign cnt_we    = clr_q | s2_adv;
  assign bim_waddr = clr_q ? clr_cnt_q[BI_W-1:0] : s2_bi_q;
  assign bim_wdata = clr_q ? '0 : bim_new;
  assign lpc_waddr = clr_q ? clr_cnt_q[LHB-1:0] : s2_lhist_q;
  assign lpc_wdata = clr_q ? '0 : lpc_new;
  assign gw_waddr  = clr_q ? clr_cnt_q[GHB-1:0] : s2_gh_q;
  assign gw_wdata  = clr_q ? '0 : gw_new;
  assign gsc_waddr = clr_q ? clr_cnt_q[GHB-1:0] : s2_gsi_q;
  assign gsc_wdata = clr_q ? '0 : gsc_new;

  assign gw_new = {gl_new, gg_new, lg_new, pair_new, gpc_new};

  bdp_ram #(.AW(BI_W), .DW(SC)) u_bim_ram (
    .clk_i   (clk_i),
    .re_i    (s1_adv),
    .raddr_i (s1_bi_q),
    .rdata_o (bim_rdata),
    .we_i    (cnt_we),
    .waddr_i (bim_waddr),
    .wdata_i (bim_wdata)
  );

  bdp_ram #(.AW(LHB), .DW(SC)) u_lpc_ram (
    .clk_i   (clk_i),
    .re_i    (s1_adv),
    .raddr_i (lh_rdata),
    .rdata_o (lpc_rdata),
    .we_i    (cnt_we),
    .waddr_i (lpc_waddr),
    .wdata_i (lpc_wdata)
  );

  bdp_ram #(.AW(GHB), .DW(GW_DW)) u_gw_ram (
    .clk_i   (clk_i),
    .re_i    (s1_adv),
    .raddr_i (s1_gh_q),
    .rdata_o (gw_rdata),
    .we_i    (cnt_we),
    .waddr_i (gw_waddr),
    .wdata_i (gw_wdata)
  );

  bdp_ram #(.AW(GHB), .DW(GC)) u_gsc_ram (
    .clk_i   (clk_i),
    .re_i    (s1_adv),
    .raddr_i (s1_gsi_q),
    .rdata_o (gsc_rdata),
    .we_i    (cnt_we),
    .waddr_i (gsc_waddr),
    .wdata_i (gsc_wdata)
  );

  // predictions and training from the pre-update counters
  bdp_resolve #(
    .SMALL_CTR_BITS  (SC),
    .GLOBAL_CTR_BITS (GC)
  ) u_resolve (
    .taken_i (s2_taken_q),
    .fwd_i   (s2_fwd_q),
    .bim_i   (bim_rdata),
    .lpc_i   (lpc_rdata),
    .gpc_i   (gw_rdata[GC-1:0]),
    .gsc_i   (gsc_rdata),
    .pair_i  (gw_rdata[PAIR_LSB +: SC]),
    .lg_i    (gw_rdata[LG_LSB +: SC]),
    .gg_i    (gw_rdata[GG_LSB +: SC]),
    .gl_i    (gw_rdata[GL_LSB +: SC]),
    .pred_o  (pred),
    .bim_o   (bim_new),
    .lpc_o   (lpc_new),
    .gpc_o   (gpc_new),
    .gsc_o   (gsc_new),
    .pair_o  (pair_new),
    .lg_o    (lg_new),
    .gg_o    (gg_new),
    .gl_o    (gl_new)
  );

  // result stream, first field in bit 0
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}},
                          out_q.tournament_pred,
                          out_q.vote_pred,
                          out_q.pair_hybrid_pred,
                          out_q.gshare_pred,
                          out_q.global_pred,
                          out_q.local_pred,
                          out_q.bimodal_pred,
                          out_q.static_pred,
                          out_q.is_forward};

  // no branch is taken in while the tables are being cleared
  a_no_intake_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !s_axis_tready)
    else $error("branch taken in during table clear");

  // the clear sweep ends only after the last entry
  a_clear_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_q) |-> ($past(clr_cnt_q) == CLR_LAST))
    else $error("table clear ended early");

  // the newest outcome lands in the global history
  a_ghist_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> (gh_q[0] == $past(in_taken)))
    else $error("global history missed an outcome");

  // a blocked stage-1 branch is not dropped
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> s1_valid_q)
    else $error("stage 1 branch lost while stalled");

endmodule

`default_nettype wire
